FILE: rtl/core/iba_pkg.sv
// Package for the indexed block allocator: sizes, status codes, sequencer states.
// No dependencies; used by indexed_block_allocator.
package iba_pkg;

	// Block map size and search group size
	localparam int NUM_BLOCKS = 64;
	localparam int MAX_LENGTH = 16;
	localparam int GRP_SIZE   = 8;
	localparam int GRP_CNT    = NUM_BLOCKS / GRP_SIZE;

	// Widths
	localparam int BLK_IDX_W = $clog2(NUM_BLOCKS);      // 0-based block index
	localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);  // counts up to NUM_BLOCKS
	localparam int GRP_W     = $clog2(GRP_CNT);
	localparam int SEL_W     = $clog2(GRP_SIZE);
	localparam int PID_W     = 8;
	localparam int LEN_W     = 5;
	localparam int BLK_NUM_W = 7;                       // 1-based block number port
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	// Register map (byte address of word)
	localparam logic [PADDR_W-1:0] ADDR_BLOCK_COUNT = 3'd0;
	localparam logic [BLK_NUM_W-1:0] BLOCK_COUNT_RST = 7'd64;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOSPACE = 2'd1,
		ST_BUSY    = 2'd2,
		ST_RANGE   = 2'd3
	} status_t;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_SEARCH
	} state_t;

endpackage

FILE: rtl/core/indexed_block_allocator.sv
// Indexed block allocator: used-block map, free count, group-wise first-free search.
// Depends on iba_pkg.
// Flow: start is taken while busy is low; the request is registered and checked in S_CHECK,
// whose result is registered to the ports; a refused item gives its single result there.
// Busy stays high through S_CHECK and S_SEARCH, including 8-block search groups skipped as
// full; one result per cycle, but none while a full group is skipped; results cannot stall.
// Reset: map cleared, block_count = 64, free count = 64. A block_count write clears it.
module indexed_block_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	// request
	input  logic                          start,
	output logic                          busy,
	input  logic [iba_pkg::PID_W-1:0]     process_id,
	input  logic [iba_pkg::LEN_W-1:0]     data_length,
	input  logic [iba_pkg::BLK_NUM_W-1:0] index_block,
	// results
	output logic                          result_valid,
	output logic [1:0]                    status,
	output logic [iba_pkg::BLK_NUM_W-1:0] block_number,
	output logic [iba_pkg::PID_W-1:0]     owner_id,
	output logic                          last,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [iba_pkg::PADDR_W-1:0]   paddr,
	input  logic [iba_pkg::PDATA_W-1:0]   pwdata,
	output logic [iba_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import iba_pkg::*;

	state_t state_q, state_d;

	logic [BLK_NUM_W-1:0] block_count_q;
	logic [CNT_W-1:0]     eff_cnt_q;
	logic [NUM_BLOCKS-1:0] used_q;
	logic [CNT_W-1:0]     free_q;

	logic [PID_W-1:0]     pid_q;
	logic [LEN_W-1:0]     len_q;
	logic [BLK_NUM_W-1:0] idx_q;
	logic [LEN_W-1:0]     rem_q;
	logic [GRP_W-1:0]     grp_q;

	logic                 res_valid_q;
	status_t              res_status_q;
	logic [BLK_NUM_W-1:0] res_block_q;
	logic                 res_last_q;

	logic                 cfg_wr;
	logic [CNT_W-1:0]     wr_eff;
	logic                 accept;

	// Request check
	logic                 chk_range;
	logic                 chk_busy;
	logic                 chk_space;
	logic [BLK_IDX_W-1:0] idx0;

	// Group search
	logic [GRP_SIZE-1:0]  avail;
	logic                 hit;
	logic [SEL_W-1:0]     hit_sel;
	logic [BLK_IDX_W-1:0] hit_blk;

	// Sequencer outputs
	logic                 emit;
	status_t              emit_status;
	logic [BLK_NUM_W-1:0] emit_block;
	logic                 emit_last;
	logic                 mark_en;
	logic [BLK_IDX_W-1:0] mark_idx;
	logic                 grp_adv;
	logic                 load_search;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1:2] == ADDR_BLOCK_COUNT[PADDR_W-1:2]);
	assign wr_eff = (pwdata[BLK_NUM_W-1:0] > BLK_NUM_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
	                                                                : CNT_W'(pwdata[BLK_NUM_W-1:0]);
	assign prdata = PDATA_W'(block_count_q);

	// Request checks, in priority order range, busy, space
	assign idx0      = BLK_IDX_W'(idx_q - BLK_NUM_W'(1));
	assign chk_range = (idx_q == '0) || (CNT_W'(idx_q) > eff_cnt_q);
	assign chk_busy  = used_q[idx0];
	assign chk_space = (len_q > LEN_W'(MAX_LENGTH)) ||
	                   (free_q < (CNT_W'(len_q) + CNT_W'(1)));

	// Free blocks within the current group, lowest first
	always_comb begin
		avail   = '0;
		hit     = 1'b0;
		hit_sel = '0;
		for (int j = 0; j < GRP_SIZE; j++) begin
			avail[j] = !used_q[{grp_q, SEL_W'(j)}] &&
			           (CNT_W'({grp_q, SEL_W'(j)}) < eff_cnt_q);
		end
		for (int j = GRP_SIZE - 1; j >= 0; j--) begin
			if (avail[j]) begin
				hit     = 1'b1;
				hit_sel = SEL_W'(j);
			end
		end
	end
	assign hit_blk = {grp_q, hit_sel};

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (chk_range || chk_busy || chk_space || (len_q == '0)) state_d = S_IDLE;
				else state_d = S_SEARCH;
			end
			S_SEARCH: begin
				if (hit) begin
					if (rem_q == LEN_W'(1)) state_d = S_IDLE;
				end else if (grp_q == GRP_W'(GRP_CNT - 1)) begin
					// full map; unreachable while the free count tracks the map
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		emit        = 1'b0;
		emit_status = ST_OK;
		emit_block  = '0;
		emit_last   = 1'b0;
		mark_en     = 1'b0;
		mark_idx    = idx0;
		grp_adv     = 1'b0;
		load_search = 1'b0;
		case (state_q)
			S_CHECK: begin
				emit      = 1'b1;
				emit_last = 1'b1;
				if (chk_range) begin
					emit_status = ST_RANGE;
				end else if (chk_busy) begin
					emit_status = ST_BUSY;
				end else if (chk_space) begin
					emit_status = ST_NOSPACE;
				end else begin
					emit_block  = idx_q;
					emit_last   = (len_q == '0);
					mark_en     = 1'b1;
					load_search = 1'b1;
				end
			end
			S_SEARCH: begin
				if (hit) begin
					emit       = 1'b1;
					emit_block = BLK_NUM_W'(hit_blk) + BLK_NUM_W'(1);
					emit_last  = (rem_q == LEN_W'(1));
					mark_en    = 1'b1;
					mark_idx   = hit_blk;
				end else begin
					grp_adv = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Control state, map and free count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			block_count_q <= BLOCK_COUNT_RST;
			eff_cnt_q     <= CNT_W'(NUM_BLOCKS);
			used_q        <= '0;
			free_q        <= CNT_W'(NUM_BLOCKS);
			res_valid_q   <= 1'b0;
			rem_q         <= '0;
			grp_q         <= '0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= emit;
			if (cfg_wr) begin
				block_count_q <= pwdata[BLK_NUM_W-1:0];
				eff_cnt_q     <= wr_eff;
				used_q        <= '0;
				free_q        <= wr_eff;
			end else if (mark_en) begin
				used_q[mark_idx] <= 1'b1;
				free_q           <= free_q - CNT_W'(1);
			end
			if (load_search) begin
				rem_q <= len_q;
				grp_q <= '0;
			end else if (state_q == S_SEARCH) begin
				if (hit) rem_q <= rem_q - LEN_W'(1);
				else if (grp_adv) grp_q <= grp_q + GRP_W'(1);
			end
		end
	end

	// Request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			pid_q <= process_id;
			len_q <= data_length;
			idx_q <= index_block;
		end
		if (emit) begin
			res_status_q <= emit_status;
			res_block_q  <= emit_block;
			res_last_q   <= emit_last;
		end
	end

	assign result_valid = res_valid_q;
	assign status       = res_status_q;
	assign block_number = res_block_q;
	assign owner_id     = pid_q;
	assign last         = res_last_q;

	// Checks
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= eff_cnt_q)
		else $error("free count above block count");

	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> busy)
		else $error("non-final result with sequencer idle");

	a_refuse_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status != ST_OK) |-> last && (block_number == '0))
		else $error("refused result not final or carries a block");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !result_valid)
		else $error("result in check cycle");

	a_grant_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == ST_OK) |-> (block_number != '0))
		else $error("granted result without block");

endmodule
